// ===== src/assert_macros.svh =====
// Assertion macros shared by the interval set RTL.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define SIS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("interval set assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define SIS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("interval set assertion failed");

`endif

// ===== src/sis_pkg.sv =====
// Package for the sorted interval set: request and status codes, time limits.
// No dependencies.
`default_nettype none
package sis_pkg;
    localparam int MAX_RANGES_DEF = 16;
    localparam int TIME_W = 32;

    localparam logic signed [TIME_W-1:0] NEG_INF = {1'b1, {(TIME_W-1){1'b0}}};
    localparam logic signed [TIME_W-1:0] POS_INF = {1'b0, {(TIME_W-1){1'b1}}};

    localparam logic [1:0] REQ_ADD      = 2'd0;
    localparam logic [1:0] REQ_CONTAINS = 2'd1;
    localparam logic [1:0] REQ_READ     = 2'd2;
    localparam logic [1:0] REQ_INVERT   = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_INDEX = 2'd1;
    localparam logic [1:0] STAT_ORDER = 2'd2;
    localparam logic [1:0] STAT_FULL  = 2'd3;
endpackage
`default_nettype wire

// ===== src/sis_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== src/sorted_interval_set_core.sv =====
// Sorted interval set core: a table of disjoint closed Q16.16 time ranges.
// Each request is taken in ST_IDLE and ends in ST_RESULT, one item at a time. Read fetches
// one entry; contains, add and invert scan the held ranges, each in ST_RD then ST_EV via
// the table RAM's single read port (add rereads one the new range lands before, and goes
// to ST_RESULT if start is after end); add and invert then pass ST_FLUSH and ST_COMMIT.
// Reset (aresetn low, synchronous) empties the set; table contents need no clearing.
`default_nettype none
`include "assert_macros.svh"
module sorted_interval_set_core #(
    parameter int MAX_RANGES = sis_pkg::MAX_RANGES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // time_a [31:0], time_b [63:32], range_index [67:64], zero pad [71:68]
    input  wire logic [71:0] s_tdata,
    // req_type [1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // hit [0], range_start [32:1], range_end [64:33], range_total [69:65], pad [71:70]
    output logic      [71:0] m_tdata,
    // status [1:0]
    output logic      [1:0]  m_tuser
);
    import sis_pkg::*;

    // Two banks in each RAM: the live table and the one being rebuilt.
    localparam int DEPTH = 2 * MAX_RANGES;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_RANGES + 1);
    localparam int KW    = $clog2(MAX_RANGES + 2);

    typedef enum logic [2:0] {
        ST_IDLE, ST_RD, ST_EV, ST_INV_END, ST_FLUSH, ST_COMMIT, ST_RESULT
    } state_t;

    state_t                     state_reg, state_next;
    logic [1:0]                 req_reg, req_next;
    logic signed [TIME_W-1:0]   a_reg, a_next;
    logic [3:0]                 idx_reg, idx_next;
    logic [CW-1:0]              i_reg, i_next;
    logic [KW-1:0]              k_reg, k_next;
    logic                       ovf_reg, ovf_next;
    logic                       pend_reg, pend_next;   // piece in s/e not yet written
    logic signed [TIME_W-1:0]   s_reg, s_next, e_reg, e_next, prev_reg, prev_next;
    logic                       hit_reg, hit_next;
    logic signed [TIME_W-1:0]   rs_reg, rs_next, re_reg, re_next;
    logic [1:0]                 stat_reg, stat_next;
    logic                       bank_reg, bank_next;
    logic [CW-1:0]              count_reg, count_next;
    logic                       mv_reg, mv_next;
    logic [71:0]                mdata_reg, mdata_next;
    logic [1:0]                 muser_reg, muser_next;

    // RAM ports
    logic                       we;
    logic [AW-1:0]              waddr, raddr;
    logic signed [TIME_W-1:0]   wd_s, wd_e, d_s, d_e;

    sis_ram #(.WIDTH(TIME_W), .DEPTH(DEPTH)) u_starts (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wd_s), .raddr(raddr), .rdata(d_s)
    );
    sis_ram #(.WIDTH(TIME_W), .DEPTH(DEPTH)) u_ends (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wd_e), .raddr(raddr), .rdata(d_e)
    );

    logic                       accept;
    logic signed [TIME_W-1:0]   in_a, in_b;
    logic [3:0]                 in_idx;
    logic                       last_entry;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_a     = s_tdata[31:0];
    assign in_b     = s_tdata[63:32];
    assign in_idx   = s_tdata[67:64];
    assign last_entry = (32'(i_reg) + 32'd1 == 32'(count_reg));

    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

    always_comb begin
        state_next = state_reg;
        req_next   = req_reg;
        a_next     = a_reg;
        idx_next   = idx_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        ovf_next   = ovf_reg;
        pend_next  = pend_reg;
        s_next     = s_reg;
        e_next     = e_reg;
        prev_next  = prev_reg;
        hit_next   = hit_reg;
        rs_next    = rs_reg;
        re_next    = re_reg;
        stat_next  = stat_reg;
        bank_next  = bank_reg;
        count_next = count_reg;
        mv_next    = mv_reg;
        mdata_next = mdata_reg;
        muser_next = muser_reg;
        we         = 1'b0;
        wd_s       = s_reg;
        wd_e       = e_reg;
        waddr      = AW'(bank_reg ? 0 : MAX_RANGES) + AW'(k_reg);
        raddr      = AW'(bank_reg ? MAX_RANGES : 0)
                     + ((req_reg == REQ_READ) ? AW'(idx_reg) : AW'(i_reg));

        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    req_next  = s_tuser;
                    a_next    = in_a;
                    idx_next  = in_idx;
                    i_next    = '0;
                    k_next    = '0;
                    ovf_next  = 1'b0;
                    hit_next  = 1'b0;
                    rs_next   = '0;
                    re_next   = '0;
                    stat_next = STAT_OK;
                    case (s_tuser)
                        REQ_ADD: begin
                            s_next    = in_a;
                            e_next    = in_b;
                            pend_next = 1'b1;
                            if (in_a > in_b) begin
                                stat_next  = STAT_ORDER;
                                state_next = ST_RESULT;
                            end else if (count_reg == '0) begin
                                state_next = ST_FLUSH;
                            end else begin
                                state_next = ST_RD;
                            end
                        end
                        REQ_CONTAINS: begin
                            state_next = (count_reg == '0) ? ST_RESULT : ST_RD;
                        end
                        REQ_READ: begin
                            if (32'(in_idx) >= 32'(count_reg)) begin
                                stat_next  = STAT_INDEX;
                                state_next = ST_RESULT;
                            end else begin
                                state_next = ST_RD;
                            end
                        end
                        default: begin
                            // empty set inverts to the whole line
                            s_next    = NEG_INF;
                            e_next    = POS_INF;
                            pend_next = (count_reg == '0);
                            state_next = (count_reg == '0) ? ST_FLUSH : ST_RD;
                        end
                    endcase
                end
            end
            ST_RD: begin
                state_next = ST_EV;
            end
            ST_EV: begin
                state_next = ST_RD;
                case (req_reg)
                    REQ_ADD: begin
                        if (d_s <= e_reg && d_e >= s_reg) begin
                            // overlap or touch: absorb the held range
                            if (d_s < s_reg) s_next = d_s;
                            if (d_e > e_reg) e_next = d_e;
                            i_next = i_reg + 1'b1;
                            if (last_entry) state_next = ST_FLUSH;
                        end else if (d_e < s_reg || !pend_reg) begin
                            // copy the held range across
                            we   = 1'b1;
                            wd_s = d_s;
                            wd_e = d_e;
                            i_next = i_reg + 1'b1;
                            if (last_entry) state_next = ST_FLUSH;
                        end else begin
                            // new range goes first; read this entry again
                            we        = 1'b1;
                            pend_next = 1'b0;
                        end
                        if (we) begin
                            if (32'(k_reg) >= MAX_RANGES) begin
                                we       = 1'b0;
                                ovf_next = 1'b1;
                            end
                            k_next = k_reg + 1'b1;
                        end
                    end
                    REQ_CONTAINS: begin
                        if (a_reg >= d_s && a_reg <= d_e) hit_next = 1'b1;
                        i_next = i_reg + 1'b1;
                        if (last_entry) state_next = ST_RESULT;
                    end
                    REQ_READ: begin
                        rs_next    = d_s;
                        re_next    = d_e;
                        state_next = ST_RESULT;
                    end
                    default: begin
                        if (i_reg == '0) begin
                            if (d_s != NEG_INF) begin
                                s_next    = NEG_INF;
                                e_next    = d_s;
                                pend_next = 1'b1;
                            end
                        end else if (pend_reg && e_reg >= prev_reg) begin
                            if (d_s > e_reg) e_next = d_s;
                        end else begin
                            we = pend_reg;
                            s_next    = prev_reg;
                            e_next    = d_s;
                            pend_next = 1'b1;
                        end
                        if (we) begin
                            if (32'(k_reg) >= MAX_RANGES) begin
                                we       = 1'b0;
                                ovf_next = 1'b1;
                            end
                            k_next = k_reg + 1'b1;
                        end
                        prev_next = d_e;
                        i_next    = i_reg + 1'b1;
                        if (last_entry) state_next = ST_INV_END;
                    end
                endcase
            end
            ST_INV_END: begin
                // trailing gap up to plus infinity
                state_next = ST_FLUSH;
                if (prev_reg != POS_INF) begin
                    if (pend_reg && e_reg >= prev_reg) begin
                        e_next = POS_INF;
                    end else begin
                        we        = pend_reg;
                        s_next    = prev_reg;
                        e_next    = POS_INF;
                        pend_next = 1'b1;
                        if (we) begin
                            if (32'(k_reg) >= MAX_RANGES) begin
                                we       = 1'b0;
                                ovf_next = 1'b1;
                            end
                            k_next = k_reg + 1'b1;
                        end
                    end
                end
            end
            ST_FLUSH: begin
                if (pend_reg) begin
                    we        = 1'b1;
                    pend_next = 1'b0;
                    if (32'(k_reg) >= MAX_RANGES) begin
                        we       = 1'b0;
                        ovf_next = 1'b1;
                    end
                    k_next = k_reg + 1'b1;
                end
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                // swap banks only when the rebuilt table fits
                if (ovf_reg) begin
                    stat_next = STAT_FULL;
                end else begin
                    bank_next  = !bank_reg;
                    count_next = CW'(k_reg);
                end
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    mdata_next = {2'b00, 5'(count_reg), re_reg, rs_reg, hit_reg};
                    muser_next = stat_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            bank_reg  <= 1'b0;
            count_reg <= '0;
            mv_reg    <= 1'b0;
            pend_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            bank_reg  <= bank_next;
            count_reg <= count_next;
            mv_reg    <= mv_next;
            pend_reg  <= pend_next;
            ovf_reg   <= ovf_next;
        end
        req_reg   <= req_next;
        a_reg     <= a_next;
        idx_reg   <= idx_next;
        i_reg     <= i_next;
        k_reg     <= k_next;
        s_reg     <= s_next;
        e_reg     <= e_next;
        prev_reg  <= prev_next;
        hit_reg   <= hit_next;
        rs_reg    <= rs_next;
        re_reg    <= re_next;
        stat_reg  <= stat_next;
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
    end

    // Held count never exceeds the table size.
    `SIS_ASSERT_IMP(a_count_max, aclk, aresetn, 1'b1, 32'(count_reg) <= MAX_RANGES)
    // Busy straight after an item is taken.
    `SIS_ASSERT_NXT(a_busy_after, aclk, aresetn, accept, !s_tready)
    // A bad index reads back as zero.
    `SIS_ASSERT_IMP(a_bad_index_zero, aclk, aresetn,
        mv_reg && muser_reg == STAT_INDEX, mdata_reg[64:1] == '0)
endmodule
`default_nettype wire

// ===== tb/sis_scoreboard.sv =====
// Checker for the sorted interval set core: watches both stream channels, predicts each result.
// Depends on sis_pkg for request and status codes and the infinity codes.
`timescale 1ns / 1ps
module sis_scoreboard (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [71:0] s_tdata,
    input  wire logic [1:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [71:0] m_tdata,
    input  wire logic [1:0]  m_tuser,
    output int               fail_count,
    output int               pending_count
);
    import sis_pkg::*;

    localparam int DEPTH = 16;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] range_start;
        logic signed [31:0] range_end;
        logic [4:0]         range_total;
        logic [1:0]         status;
    } set_answer_t;

    logic signed [31:0] lo_tab [DEPTH];
    logic signed [31:0] hi_tab [DEPTH];
    int                 held;
    logic signed [31:0] acc_lo [DEPTH+1];
    logic signed [31:0] acc_hi [DEPTH+1];
    int                 acc_n;
    set_answer_t        answer_q [$];

    assign pending_count = answer_q.size();

    // Merge [s,e] into the accumulator; the union lands in sorted order.
    task automatic merge_range(input logic signed [31:0] s, input logic signed [31:0] e);
        logic signed [31:0] nl [DEPTH+2];
        logic signed [31:0] nh [DEPTH+2];
        int k;
        bit placed;
        k = 0;
        placed = 0;
        for (int i = 0; i < acc_n; i++) begin
            if (acc_lo[i] <= e && acc_hi[i] >= s) begin
                if (acc_lo[i] < s) s = acc_lo[i];
                if (acc_hi[i] > e) e = acc_hi[i];
            end else if (acc_hi[i] < s) begin
                nl[k] = acc_lo[i]; nh[k] = acc_hi[i]; k++;
            end else begin
                if (!placed) begin
                    nl[k] = s; nh[k] = e; k++; placed = 1;
                end
                nl[k] = acc_lo[i]; nh[k] = acc_hi[i]; k++;
            end
        end
        if (!placed) begin
            nl[k] = s; nh[k] = e; k++;
        end
        for (int i = 0; i < k && i <= DEPTH; i++) begin
            acc_lo[i] = nl[i]; acc_hi[i] = nh[i];
        end
        acc_n = k;
    endtask

    task automatic predict_request(input logic [1:0] req, input logic [71:0] d);
        logic signed [31:0] ta, tb;
        logic [3:0]         idx;
        set_answer_t        r;
        ta  = d[31:0];
        tb  = d[63:32];
        idx = d[67:64];
        r   = '0;
        r.status = STAT_OK;
        case (req)
            REQ_ADD: begin
                if (ta > tb) begin
                    r.status = STAT_ORDER;
                end else begin
                    acc_n = held;
                    for (int i = 0; i < held; i++) begin
                        acc_lo[i] = lo_tab[i]; acc_hi[i] = hi_tab[i];
                    end
                    merge_range(ta, tb);
                    if (acc_n > DEPTH) r.status = STAT_FULL;
                    else commit_acc();
                end
            end
            REQ_CONTAINS: begin
                for (int i = 0; i < held; i++)
                    if (ta >= lo_tab[i] && ta <= hi_tab[i]) r.hit = 1'b1;
            end
            REQ_READ: begin
                if (idx >= held) begin
                    r.status = STAT_INDEX;
                end else begin
                    r.range_start = lo_tab[idx];
                    r.range_end   = hi_tab[idx];
                end
            end
            default: begin
                acc_n = 0;
                if (held == 0) begin
                    merge_range(NEG_INF, POS_INF);
                end else begin
                    if (lo_tab[0] != NEG_INF) merge_range(NEG_INF, lo_tab[0]);
                    for (int i = 0; i + 1 < held && acc_n <= DEPTH; i++)
                        merge_range(hi_tab[i], lo_tab[i+1]);
                    if (acc_n <= DEPTH && hi_tab[held-1] != POS_INF)
                        merge_range(hi_tab[held-1], POS_INF);
                end
                if (acc_n > DEPTH) r.status = STAT_FULL;
                else commit_acc();
            end
        endcase
        r.range_total = 5'(held);
        answer_q.push_back(r);
    endtask

    task automatic commit_acc();
        for (int i = 0; i < acc_n; i++) begin
            lo_tab[i] = acc_lo[i]; hi_tab[i] = acc_hi[i];
        end
        held = acc_n;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            held = 0;
            answer_q.delete();
        end else begin
            if (s_tvalid && s_tready) predict_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready) check_answer();
        end
    end

    task automatic check_answer();
        set_answer_t want;
        if (answer_q.size() == 0) begin
            $error("result with no request pending");
            fail_count++;
            return;
        end
        want = answer_q.pop_front();
        if (m_tdata[0] !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, m_tdata[0]);
            fail_count++;
        end
        if ($signed(m_tdata[32:1]) !== want.range_start) begin
            $error("range_start: expected %0d, got %0d", want.range_start,
                   $signed(m_tdata[32:1]));
            fail_count++;
        end
        if ($signed(m_tdata[64:33]) !== want.range_end) begin
            $error("range_end: expected %0d, got %0d", want.range_end,
                   $signed(m_tdata[64:33]));
            fail_count++;
        end
        if (m_tdata[69:65] !== want.range_total) begin
            $error("range_total: expected %0d, got %0d", want.range_total, m_tdata[69:65]);
            fail_count++;
        end
        if (m_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tuser);
            fail_count++;
        end
    endtask

    initial fail_count = 0;
endmodule

// ===== tb/tb_sorted_interval_set_core.sv =====
// Testbench top for the sorted interval set core: clock, reset, stimulus and verdict.
// Depends on sis_pkg, the core and the sis_scoreboard checker.
`timescale 1ns / 1ps
module tb_sorted_interval_set_core;
    import sis_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;
    int          fail_count;
    int          pending_count;
    int          items_sent = 0;
    bit          hold_sink = 0;
    // Pool of recent endpoints; reused so that new ranges touch and overlap old ones.
    logic signed [31:0] endpoint_pool [$];

    sorted_interval_set_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    sis_scoreboard checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Pick a time: extremes, values near earlier endpoints, small values, or raw bits.
    function automatic logic signed [31:0] pick_time();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5) return NEG_INF;
        if (roll < 10) return POS_INF;
        if (roll < 40 && endpoint_pool.size() > 0)
            return endpoint_pool[$urandom_range(0, endpoint_pool.size() - 1)]
                   + $signed(32'($urandom_range(0, 2))) - 1;
        if (roll < 85) return $signed(32'($urandom_range(0, 4000))) - 2000;
        return $signed($urandom());
    endfunction

    // Offer one item and hold it until the core takes it.
    // Ready is sampled mid-cycle so the accepting edge is known without a race.
    task automatic send_item(input logic [1:0] req, input logic signed [31:0] ta,
                             input logic signed [31:0] tb, input logic [3:0] idx);
        int gap;
        bit ready_seen;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {4'b0, idx, tb, ta};
        do begin
            @(negedge aclk);
            ready_seen = s_tready;
            @(posedge aclk);
        end while (!ready_seen);
        items_sent++;
        if (endpoint_pool.size() > 40) void'(endpoint_pool.pop_front());
        endpoint_pool.push_back(ta);
        endpoint_pool.push_back(tb);
    endtask

    task automatic send_random();
        int roll;
        logic signed [31:0] ta, tb, t;
        roll = $urandom_range(0, 99);
        ta = pick_time();
        tb = pick_time();
        if (roll < 45) begin
            // mostly well-ordered adds, now and then a swapped pair
            if (ta > tb && $urandom_range(0, 9) != 0) begin
                t = ta; ta = tb; tb = t;
            end
            send_item(REQ_ADD, ta, tb, 4'($urandom()));
        end else if (roll < 70) begin
            send_item(REQ_CONTAINS, ta, tb, 4'($urandom()));
        end else if (roll < 90) begin
            send_item(REQ_READ, ta, tb, 4'($urandom()));
        end else begin
            send_item(REQ_INVERT, ta, tb, 4'($urandom()));
        end
    endtask

    // Receiver: random ready, and a long hold-off on request.
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            if (hold_sink) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_sink = 0;
            end
            gap = pick_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    initial begin
        int waited;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty set, extremes, every request, each special case.
        send_item(REQ_READ, 0, 0, 4'd0);
        send_item(REQ_CONTAINS, 0, 0, 4'd0);
        send_item(REQ_INVERT, 0, 0, 4'd0);
        send_item(REQ_READ, 0, 0, 4'd0);
        send_item(REQ_CONTAINS, NEG_INF, 0, 4'd0);
        send_item(REQ_INVERT, 0, 0, 4'd15);
        send_item(REQ_ADD, 32'sd5, -32'sd5, 4'd0);
        send_item(REQ_ADD, -32'sd100, 32'sd100, 4'd0);
        send_item(REQ_ADD, 32'sd100, 32'sd200, 4'd0);
        send_item(REQ_ADD, NEG_INF, -32'sd1000, 4'd0);
        send_item(REQ_ADD, 32'sd5000, POS_INF, 4'd0);
        send_item(REQ_READ, 0, 0, 4'd2);
        send_item(REQ_READ, 0, 0, 4'd3);
        send_item(REQ_CONTAINS, POS_INF, 0, 4'd0);
        send_item(REQ_INVERT, 0, 0, 4'd0);
        send_item(REQ_READ, 0, 0, 4'd0);
        send_item(REQ_ADD, NEG_INF, POS_INF, 4'd0);
        send_item(REQ_INVERT, 0, 0, 4'd0);
        // Fill the table with sixteen points, then overflow by add and by invert.
        for (int i = 0; i < 16; i++)
            send_item(REQ_ADD, 32'(i * 10), 32'(i * 10), 4'd0);
        send_item(REQ_READ, 0, 0, 4'd15);
        send_item(REQ_ADD, 32'sd500, 32'sd600, 4'd0);
        send_item(REQ_INVERT, 0, 0, 4'd0);

        // Random part; drop the set back to empty now and then so it refills.
        for (int i = 0; i < 600; i++) begin
            if (i == 300) hold_sink = 1;
            if (i % 90 == 89) begin
                send_item(REQ_ADD, NEG_INF, POS_INF, 4'd0);
                send_item(REQ_INVERT, 0, 0, 4'd0);
            end
            send_random();
        end
        s_tvalid <= 1'b0;

        waited = 0;
        while (pending_count != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (100) @(posedge aclk);
        $display("Run covered %0d requests: adds with merging, queries, reads, inversions,",
                 items_sent);
        $display("table-full and bad-order cases, and a long receiver stall.");
        if (fail_count == 0 && pending_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end
endmodule
